FILE: hdl/oaht_pkg.sv
// Shared constants, types and helpers for the open-address hash table unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package oaht_pkg;
  localparam int TableSlots = 64;
  localparam int SlotW = $clog2(TableSlots);
  localparam int KeyChars = 32;
  localparam int KeyBits = 256;
  localparam int KeyWords = 4;
  localparam int CharCntW = 6;
  localparam logic [30:0] ModP = 31'h7FFF_FFFF;
  localparam logic [31:0] PhiFix = 32'h9E37_79B9;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_FILLED = 2'd1;

  typedef struct packed {
    logic load;
    logic hash_step;
    logic map_mul;
    logic map_home;
    logic probe_start;
    logic probe_next;
    logic cmp_start;
    logic cmp_step;
    logic write_step;
  } oaht_cmd_t;

  typedef struct packed {
    logic clearing;
    logic hash_done;
    logic mark_empty;
    logic mark_filled;
    logic cmp_done;
    logic cmp_equal;
    logic write_done;
  } oaht_stat_t;

  function automatic logic [30:0] mod_add(input logic [30:0] a, input logic [30:0] b);
    logic [31:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, ModP}) s = s - {1'b0, ModP};
    return s[30:0];
  endfunction
endpackage
`default_nettype wire

FILE: hdl/oaht_ctrl.sv
// Controller state machine for the hash table unit.
// Depends on oaht_pkg.
`timescale 1ns / 1ps
`default_nettype none
module oaht_ctrl import oaht_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       in_command,
  output logic            in_stall,
  output logic            out_valid,
  input  wire logic       out_stall,
  output oaht_cmd_t       cmd,
  input  oaht_stat_t      stat,
  output logic [1:0]      res_status,
  output logic            res_use_slot
);
  localparam logic [3:0] S_IDLE = 4'd0, S_HASH = 4'd1, S_MUL = 4'd2, S_HOME = 4'd3,
    S_RD = 4'd4, S_EVAL = 4'd5, S_CMP = 4'd6, S_WRITE = 4'd7, S_OUT = 4'd8,
    S_SCAN = 4'd9, S_SEVAL = 4'd10;

  logic [3:0] state, state_next;
  logic insert;
  logic [SlotW:0] probes, probes_next;
  logic [1:0] status_next;
  logic use_next;

  assign in_stall = (state != S_IDLE) || stat.clearing;
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    cmd = '0;
    probes_next = probes;
    status_next = res_status;
    use_next = res_use_slot;
    case (state)
      S_IDLE: begin
        if (in_valid && !stat.clearing) begin
          cmd.load = 1'b1;
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        if (stat.hash_done) state_next = S_MUL;
      end
      S_MUL: begin
        cmd.map_mul = 1'b1;
        state_next = S_HOME;
      end
      S_HOME: begin
        cmd.map_home = 1'b1;
        cmd.probe_start = 1'b1;
        probes_next = '0;
        state_next = S_RD;
      end
      S_RD: state_next = S_EVAL;
      S_EVAL: begin
        if (probes == (SlotW + 1)'(TableSlots)) begin
          if (insert) begin
            cmd.probe_start = 1'b1;
            probes_next = '0;
            state_next = S_SCAN;
          end else begin
            status_next = ST_ABSENT;
            use_next = 1'b0;
            state_next = S_OUT;
          end
        end else if (stat.mark_empty) begin
          if (insert) begin
            cmd.probe_start = 1'b1;
            probes_next = '0;
            state_next = S_SCAN;
          end else begin
            status_next = ST_ABSENT;
            use_next = 1'b0;
            state_next = S_OUT;
          end
        end else if (stat.mark_filled) begin
          cmd.cmp_start = 1'b1;
          state_next = S_CMP;
        end else begin
          cmd.probe_next = 1'b1;
          probes_next = probes + 1'b1;
          state_next = S_RD;
        end
      end
      S_CMP: begin
        cmd.cmp_step = 1'b1;
        if (stat.cmp_done) begin
          if (stat.cmp_equal) begin
            if (insert) begin
              state_next = S_WRITE;
            end else begin
              status_next = ST_OK;
              use_next = 1'b1;
              state_next = S_OUT;
            end
          end else begin
            cmd.probe_next = 1'b1;
            probes_next = probes + 1'b1;
            state_next = S_RD;
          end
        end
      end
      S_SCAN: state_next = S_SEVAL;
      S_SEVAL: begin
        if (probes == (SlotW + 1)'(TableSlots)) begin
          status_next = ST_FULL;
          use_next = 1'b0;
          state_next = S_OUT;
        end else if (!stat.mark_filled) begin
          state_next = S_WRITE;
        end else begin
          cmd.probe_next = 1'b1;
          probes_next = probes + 1'b1;
          state_next = S_SCAN;
        end
      end
      S_WRITE: begin
        cmd.write_step = 1'b1;
        if (stat.write_done) begin
          status_next = ST_OK;
          use_next = 1'b1;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      probes <= '0;
      res_status <= ST_OK;
      res_use_slot <= 1'b0;
      insert <= 1'b0;
    end else begin
      state <= state_next;
      probes <= probes_next;
      res_status <= status_next;
      res_use_slot <= use_next;
      if (cmd.load) insert <= (in_command == CMD_INSERT);
    end
  end
endmodule
`default_nettype wire

FILE: hdl/oaht_dp.sv
// Datapath: key normalization, hash, slot mapping, mark and key stores.
// Depends on oaht_pkg.
`timescale 1ns / 1ps
`default_nettype none
module oaht_dp import oaht_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [KeyBits-1:0]  in_key,
  input  oaht_cmd_t                cmd,
  output oaht_stat_t               stat,
  output logic [SlotW-1:0]         slot
);
  logic [KeyBits-1:0] key;
  logic [CharCntW-1:0] ch;
  logic hdone;
  logic [30:0] h, pw;
  logic [31:0] frac;
  logic [SlotW-1:0] home;
  logic [1:0] marks [TableSlots];
  logic [1:0] mark_q;
  logic clearing;
  logic [SlotW-1:0] clr_idx;
  logic [63:0] kmem [TableSlots*KeyWords];
  logic [63:0] krd;
  logic [1:0] kw;
  logic [2:0] cmp_cnt;
  logic eq;
  logic [2:0] wr_cnt;
  logic [KeyBits-1:0] norm;
  logic ended;
  logic [7:0] b;
  logic [30:0] term;
  logic [61:0] prod;
  logic [30:0] prod_mod;
  logic [32:0] pw3;
  logic [63:0] hm;
  logic [2*SlotW+31:0] hs;
  logic [SlotW+1:0] kaddr;
  logic [63:0] keyw;

  always_comb begin
    norm = '0;
    ended = 1'b0;
    for (int n = 0; n < 32; n++) begin
      if (n >= KeyChars || in_key[8*n +: 8] == 8'd0) ended = 1'b1;
      if (!ended) norm[8*n +: 8] = in_key[8*n +: 8];
    end
  end

  assign b = key[8*ch +: 8];
  assign term = (b >= 8'd97) ? 31'(b - 8'd97) : (ModP - 31'(8'd97 - b));
  assign prod = term * pw;
  assign prod_mod = mod_add(prod[61:31], prod[30:0]);
  assign pw3 = {2'b00, pw} + {1'b0, pw, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      hdone <= 1'b0;
    end else if (cmd.load) begin
      key <= norm;
      ch <= '0;
      h <= '0;
      pw <= 31'd1;
      hdone <= (norm[7:0] == 8'd0);
    end else if (cmd.hash_step && !hdone) begin
      h <= mod_add(h, prod_mod);
      pw <= mod_add(31'(pw3[32:31]), pw3[30:0]);
      ch <= ch + 1'b1;
      if (ch == CharCntW'(KeyChars - 1) || key[8*(ch+1) +: 8] == 8'd0) hdone <= 1'b1;
    end
  end
  assign stat.hash_done = hdone;

  assign hm = {33'd0, h} * {32'd0, PhiFix};
  always_ff @(posedge clk) begin
    if (cmd.map_mul) frac <= hm[31:0];
  end
  assign hs = {{(2*SlotW){1'b0}}, frac} * (2*SlotW+32)'(TableSlots);
  assign home = hs[32 +: SlotW];

  always_ff @(posedge clk) begin
    if (cmd.map_home) slot <= home;
    else if (cmd.probe_start) slot <= home;
    else if (cmd.probe_next) slot <= slot + 1'b1;
  end

  always_ff @(posedge clk) begin
    mark_q <= marks[slot];
  end
  assign stat.mark_empty = (mark_q == MARK_EMPTY);
  assign stat.mark_filled = (mark_q == MARK_FILLED);

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == SlotW'(TableSlots - 1)) clearing <= 1'b0;
    end
  end
  assign stat.clearing = clearing;

  always_ff @(posedge clk) begin
    if (clearing) begin
      marks[clr_idx] <= MARK_EMPTY;
    end else if (cmd.write_step && wr_cnt == 3'(KeyWords - 1)) begin
      marks[slot] <= MARK_FILLED;
    end
  end

  assign kaddr = {slot, cmd.write_step ? wr_cnt[1:0] : kw};
  assign keyw = key[64*kaddr[1:0] +: 64];
  always_ff @(posedge clk) begin
    if (cmd.write_step) kmem[kaddr] <= keyw;
    krd <= kmem[kaddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kw <= '0;
      cmp_cnt <= '0;
      eq <= 1'b1;
      wr_cnt <= '0;
    end else begin
      if (cmd.cmp_start) begin
        kw <= 2'd1;
        cmp_cnt <= '0;
        eq <= 1'b1;
      end else if (cmd.cmp_step) begin
        if (cmp_cnt == 3'(KeyWords - 1)) begin
          kw <= '0;
          cmp_cnt <= '0;
        end else begin
          kw <= kw + 1'b1;
          cmp_cnt <= cmp_cnt + 1'b1;
          if (krd != key[64*cmp_cnt[1:0] +: 64]) eq <= 1'b0;
        end
      end
      if (cmd.write_step) begin
        wr_cnt <= (wr_cnt == 3'(KeyWords - 1)) ? 3'd0 : wr_cnt + 1'b1;
      end
    end
  end
  assign stat.cmp_done = (cmp_cnt == 3'(KeyWords - 1));
  assign stat.cmp_equal = eq && (krd == key[64*cmp_cnt[1:0] +: 64]);
  assign stat.write_done = (wr_cnt == 3'(KeyWords - 1));
endmodule
`default_nettype wire

FILE: hdl/open_address_hash_table_unit.sv
// Top level of the open-address hash table unit.
// Depends on oaht_pkg, oaht_ctrl and oaht_dp.
//
//   channel | signals                                         | direction
//   in      | in_valid, in_stall, command, key_chars_*       | request in
//   out     | out_valid, out_stall, status, slot_index       | result out
//
// One request at a time: hashing steps through the key characters, then the
// home slot is mapped through S_MUL and S_HOME. Each probed slot reads its
// mark, and the key of a filled slot is compared word by word; an insert scan
// reads each slot's mark in turn and the write stores the key words. After
// reset a pass over all 64 slots clears the marks while requests stall. A
// stalled result holds the unit; the next request waits until it is taken.
`timescale 1ns / 1ps
`default_nettype none
module open_address_hash_table_unit import oaht_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        command,
  input  wire logic [63:0] key_chars_0_7,
  input  wire logic [63:0] key_chars_8_15,
  input  wire logic [63:0] key_chars_16_23,
  input  wire logic [63:0] key_chars_24_31,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [5:0]       slot_index
);
  oaht_cmd_t cmd;
  oaht_stat_t stat;
  logic [SlotW-1:0] slot;
  logic [1:0] res_status;
  logic res_use_slot;

  oaht_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_command(command),
    .in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
    .cmd(cmd), .stat(stat), .res_status(res_status), .res_use_slot(res_use_slot)
  );

  oaht_dp u_dp (
    .clk(clk), .rst(rst),
    .in_key({key_chars_24_31, key_chars_16_23, key_chars_8_15, key_chars_0_7}),
    .cmd(cmd), .stat(stat), .slot(slot)
  );

  assign status = res_status;
  assign slot_index = res_use_slot ? 6'(slot) : 6'd0;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("request accepted while result pending");
  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> slot_index == 6'd0)
    else $error("nonzero slot with failing status");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status)))
    else $error("result dropped while stalled");
endmodule
`default_nettype wire
